/* src/yuv2rgb_pkg.sv */
// Shared types, constants and coefficient lookup for the packed 4:2:2 to RGB converter.
// No dependencies; used by yuv2rgb_conv and packed_yuv422_to_rgb.

package yuv2rgb_pkg;

	// Matrix selection codes; the unused code falls back to BT.601
	typedef enum logic [1:0] {
		ENC_BT601  = 2'd0,
		ENC_BT709  = 2'd1,
		ENC_BT2020 = 2'd2
	} encoding_t;

	// Configuration register indexes
	localparam logic [1:0] REG_COLOR_ENCODING       = 2'd0;
	localparam logic [1:0] REG_LUMA_POSITION        = 2'd1;
	localparam logic [1:0] REG_BLUE_CHROMA_POSITION = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 2;

	// Reset values of the configuration registers
	localparam logic [1:0] COLOR_ENCODING_RST       = 2'd0;
	localparam logic       LUMA_POSITION_RST        = 1'b0;
	localparam logic [1:0] BLUE_CHROMA_POSITION_RST = 2'd1;

	// Fixed-point arithmetic: 8-bit fraction, sums kept in 20 bits signed
	localparam int SUM_W = 20;
	localparam int COEF_W = 10;
	localparam logic [7:0] Y_OFFSET = 8'd16;
	localparam logic [7:0] C_OFFSET = 8'd128;
	localparam logic [COEF_W-1:0] Y_COEF = 10'd298;
	localparam logic signed [SUM_W-1:0] ROUND_BIAS = 20'sd128;

	typedef struct packed {
		logic [COEF_W-1:0] kr;
		logic [COEF_W-1:0] kgd;
		logic [COEF_W-1:0] kge;
		logic [COEF_W-1:0] kb;
	} coef_t;

	// Chroma coefficients for each standard
	function automatic coef_t coefs(input logic [1:0] enc);
		coef_t k;
		case (enc)
			ENC_BT709: begin
				k = '{kr: 10'd459, kgd: 10'd55, kge: 10'd136, kb: 10'd541};
			end
			ENC_BT2020: begin
				k = '{kr: 10'd430, kgd: 10'd48, kge: 10'd167, kb: 10'd548};
			end
			default: begin
				k = '{kr: 10'd409, kgd: 10'd100, kge: 10'd208, kb: 10'd516};
			end
		endcase
		return k;
	endfunction

endpackage

/* src/yuv2rgb_conv.sv */
// Combinational YCbCr to RGB matrix for one pixel, with rounding and clipping.
// Depends on yuv2rgb_pkg for coefficients and arithmetic widths.

module yuv2rgb_conv (
	input  logic [1:0] encoding,
	input  logic [7:0] y,
	input  logic [7:0] cb,
	input  logic [7:0] cr,
	output logic [7:0] r,
	output logic [7:0] g,
	output logic [7:0] b
);

	yuv2rgb_pkg::coef_t k;
	logic signed [yuv2rgb_pkg::SUM_W-1:0] c_val, d_val, e_val;
	logic signed [yuv2rgb_pkg::SUM_W-1:0] luma_term;
	logic signed [yuv2rgb_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;

	// Add rounding bias, drop the fraction and saturate to 0..255
	function automatic logic [7:0] clip8(input logic signed [yuv2rgb_pkg::SUM_W-1:0] s);
		logic signed [yuv2rgb_pkg::SUM_W-1:0] v;
		logic [7:0] res;
		v = s + yuv2rgb_pkg::ROUND_BIAS;
		if (v < 0) begin
			res = 8'd0;
		end else if (v[yuv2rgb_pkg::SUM_W-2:16] != '0) begin
			res = 8'd255;
		end else begin
			res = v[15:8];
		end
		return res;
	endfunction

	assign k = yuv2rgb_pkg::coefs(encoding);

	// Remove the offsets from the samples
	assign c_val = yuv2rgb_pkg::SUM_W'(signed'({1'b0, y}))
		- yuv2rgb_pkg::SUM_W'(signed'({1'b0, yuv2rgb_pkg::Y_OFFSET}));
	assign d_val = yuv2rgb_pkg::SUM_W'(signed'({1'b0, cb}))
		- yuv2rgb_pkg::SUM_W'(signed'({1'b0, yuv2rgb_pkg::C_OFFSET}));
	assign e_val = yuv2rgb_pkg::SUM_W'(signed'({1'b0, cr}))
		- yuv2rgb_pkg::SUM_W'(signed'({1'b0, yuv2rgb_pkg::C_OFFSET}));

	// Constant-coefficient products and channel sums
	assign luma_term = c_val * yuv2rgb_pkg::SUM_W'(signed'({1'b0, yuv2rgb_pkg::Y_COEF}));
	assign sum_r = luma_term + e_val * yuv2rgb_pkg::SUM_W'(signed'({1'b0, k.kr}));
	assign sum_g = luma_term - d_val * yuv2rgb_pkg::SUM_W'(signed'({1'b0, k.kgd}))
		- e_val * yuv2rgb_pkg::SUM_W'(signed'({1'b0, k.kge}));
	assign sum_b = luma_term + d_val * yuv2rgb_pkg::SUM_W'(signed'({1'b0, k.kb}));

	assign r = clip8(sum_r);
	assign g = clip8(sum_g);
	assign b = clip8(sum_b);

endmodule

/* src/packed_yuv422_to_rgb.sv */
// Packed 4:2:2 macropixel to two RGB pixels, one shared converter per cycle.
// Each macropixel waits in the macropixel register while its first, then second pixel
// moves to the pixel register; a new one can enter as the second pixel moves on.
// Throughput: one pixel per cycle while out_stall is low, set by the single converter.
// Reset (arst_n low, asynchronous) empties both stages and loads the register defaults.
// Depends on yuv2rgb_pkg and yuv2rgb_conv.

module packed_yuv422_to_rgb (
	input  logic                                clk,
	input  logic                                arst_n,
	// macropixel channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [31:0]                         macropixel,
	// pixel channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	output logic                                second_pixel,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [yuv2rgb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [yuv2rgb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [1:0]  color_encoding_q;
	logic        luma_position_q;
	logic [1:0]  blue_chroma_position_q;

	logic        valid_s1;
	logic        phase_s1;
	logic [31:0] macropixel_s1;

	logic        valid_s2;
	logic        second_s2;
	logic [7:0]  red_s2, green_s2, blue_s2;

	logic        advance;
	logic        fire;
	logic        accept;
	logic [1:0]  luma_idx, cb_idx, cr_idx;
	logic [7:0]  y_sel, cb_sel, cr_sel;
	logic [7:0]  r_new, g_new, b_new;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_encoding_q       <= yuv2rgb_pkg::COLOR_ENCODING_RST;
			luma_position_q        <= yuv2rgb_pkg::LUMA_POSITION_RST;
			blue_chroma_position_q <= yuv2rgb_pkg::BLUE_CHROMA_POSITION_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				yuv2rgb_pkg::REG_COLOR_ENCODING: begin
					color_encoding_q <= cfg_data[1:0];
				end
				yuv2rgb_pkg::REG_LUMA_POSITION: begin
					luma_position_q <= cfg_data[0];
				end
				yuv2rgb_pkg::REG_BLUE_CHROMA_POSITION: begin
					blue_chroma_position_q <= cfg_data[1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Handshake: the pixel register moves when empty or drained; the macropixel
	// register frees once its second pixel moves on
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !(phase_s1 && advance);
	assign accept   = in_valid && !in_stall;

	// Macropixel stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			phase_s1 <= 1'b0;
		end else if (fire && phase_s1) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (fire) begin
			phase_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			macropixel_s1 <= macropixel;
		end
	end

	// Pick luma for this phase and the shared chroma bytes
	assign luma_idx = {phase_s1, luma_position_q};
	assign cb_idx   = blue_chroma_position_q;
	assign cr_idx   = {~blue_chroma_position_q[1], blue_chroma_position_q[0]};
	assign y_sel    = macropixel_s1[luma_idx*8 +: 8];
	assign cb_sel   = macropixel_s1[cb_idx*8 +: 8];
	assign cr_sel   = macropixel_s1[cr_idx*8 +: 8];

	yuv2rgb_conv u_conv (
		.encoding (color_encoding_q),
		.y        (y_sel),
		.cb       (cb_sel),
		.cr       (cr_sel),
		.r        (r_new),
		.g        (g_new),
		.b        (b_new)
	);

	// Pixel stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			red_s2    <= r_new;
			green_s2  <= g_new;
			blue_s2   <= b_new;
			second_s2 <= phase_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign red          = red_s2;
	assign green        = green_s2;
	assign blue         = blue_s2;
	assign second_pixel = second_s2;

	// While the second pixel waits, the first must still sit in the pixel register
	a_first_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && phase_s1) |-> (valid_s2 && !second_s2))
		else $error("second pixel pending without first pixel in output register");

	// A macropixel is only taken into a free or freeing stage
	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!valid_s1 || (phase_s1 && advance)))
		else $error("macropixel accepted over an unfinished one");

	// A new macropixel always starts with its first pixel
	a_accept_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (valid_s1 && !phase_s1))
		else $error("accepted macropixel did not start at first pixel");

endmodule

/* dv/packed_yuv422_to_rgb_checker.sv */
// Scoreboard for the packed 4:2:2 to RGB converter: tracks register writes, predicts both pixels
// of every macropixel transfer and compares them with the pixel channel. Depends on yuv2rgb_pkg.
`timescale 1ns / 100ps

module packed_yuv422_to_rgb_checker
	import yuv2rgb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [31:0]            macropixel,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [7:0]             red,
	input  logic [7:0]             green,
	input  logic [7:0]             blue,
	input  logic                   second_pixel,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     failures,
	output int                     pending,
	output int                     pixels_checked
);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_of_pair;
	} pixel_t;

	// Shadow copy of the configuration registers
	logic [1:0] encoding_sel;
	logic       luma_pos;
	logic [1:0] cb_pos;

	pixel_t expected_pixels[$];
	int     mismatches;
	int     checked;

	// Clip a fixed-point sum with rounding to one 8-bit channel
	function automatic logic [7:0] saturate(input int sum);
		int v;
		v = sum + 128;
		if (v < 0)
			return 8'd0;
		v = v >>> 8;
		if (v > 255)
			return 8'hFF;
		return v[7:0];
	endfunction

	function automatic logic [7:0] pick_byte(input logic [31:0] word, input logic [1:0] pos);
		return word[pos*8 +: 8];
	endfunction

	// Run one luma sample and the shared chroma through the selected matrix
	function automatic pixel_t convert(input logic [7:0] y, input logic [7:0] cb,
			input logic [7:0] cr, input logic last);
		int c, d, e;
		int kr, kgd, kge, kb;
		pixel_t px;
		c = int'(y) - 16;
		d = int'(cb) - 128;
		e = int'(cr) - 128;
		case (encoding_sel)
			ENC_BT709: begin
				kr = 459; kgd = 55; kge = 136; kb = 541;
			end
			ENC_BT2020: begin
				kr = 430; kgd = 48; kge = 167; kb = 548;
			end
			// BT.601, and the spare code falls back to it
			default: begin
				kr = 409; kgd = 100; kge = 208; kb = 516;
			end
		endcase
		px.red          = saturate(298 * c + kr * e);
		px.green        = saturate(298 * c - kgd * d - kge * e);
		px.blue         = saturate(298 * c + kb * d);
		px.last_of_pair = last;
		return px;
	endfunction

	// Queue both pixels of one macropixel; byte positions wrap within the word
	task automatic predict_pair(input logic [31:0] word);
		logic [7:0] cb, cr;
		logic [1:0] first_y;
		cb = pick_byte(word, cb_pos);
		cr = pick_byte(word, cb_pos + 2'd2);
		first_y = {1'b0, luma_pos};
		expected_pixels.push_back(convert(pick_byte(word, first_y), cb, cr, 1'b0));
		expected_pixels.push_back(convert(pick_byte(word, first_y + 2'd2), cb, cr, 1'b1));
	endtask

	task automatic check_channel(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Track configuration, predict on macropixel transfers, compare on pixel transfers
	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			encoding_sel = COLOR_ENCODING_RST;
			luma_pos     = LUMA_POSITION_RST;
			cb_pos       = BLUE_CHROMA_POSITION_RST;
			expected_pixels.delete();
			mismatches   = 0;
			checked      = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COLOR_ENCODING:       encoding_sel = cfg_data[1:0];
					REG_LUMA_POSITION:        luma_pos     = cfg_data[0];
					REG_BLUE_CHROMA_POSITION: cb_pos       = cfg_data[1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel transfer with no pixel expected: r=%0d g=%0d b=%0d",
						red, green, blue);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					check_channel("red", want.red, red);
					check_channel("green", want.green, green);
					check_channel("blue", want.blue, blue);
					check_channel("second_pixel", {7'd0, want.last_of_pair},
						{7'd0, second_pixel});
					checked++;
				end
			end
			if (in_valid && !in_stall)
				predict_pair(macropixel);
		end
		failures       <= mismatches;
		pending        <= expected_pixels.size();
		pixels_checked <= checked;
	end

endmodule

/* dv/packed_yuv422_to_rgb_tb.sv */
// Top-level testbench for packed_yuv422_to_rgb: clock, reset, macropixel, stall and register
// stimulus plus the verdict. Depends on yuv2rgb_pkg, the block and packed_yuv422_to_rgb_checker.
`timescale 1ns / 100ps

module packed_yuv422_to_rgb_tb;
	import yuv2rgb_pkg::*;

	localparam logic [1:0] ENC_SPARE       = 2'd3;
	localparam int         RANDOM_PHASES   = 10;
	localparam int         ITEMS_PER_PHASE = 50;
	localparam int         HOLD_PHASE      = 2;
	localparam int         PAUSE_PHASE     = 5;
	localparam int         HOLD_LEN        = 300;
	localparam int         DRAIN_CYCLES    = 8;
	localparam int         CYCLE_LIMIT     = 200000;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [31:0]            macropixel;
	logic                   out_valid;
	logic                   out_stall;
	logic [7:0]             red;
	logic [7:0]             green;
	logic [7:0]             blue;
	logic                   second_pixel;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int   failures;
	int   pending;
	int   pixels_checked;
	int   sent;
	int   settings_loaded;
	int   burst_left;
	logic hold_req;

	packed_yuv422_to_rgb DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.macropixel   (macropixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.second_pixel (second_pixel),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	packed_yuv422_to_rgb_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.macropixel     (macropixel),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.second_pixel   (second_pixel),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.failures       (failures),
		.pending        (pending),
		.pixels_checked (pixels_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly random words; the rest built from bytes near the video levels and the rails
	function automatic logic [31:0] rand_word();
		logic [31:0] word;
		word = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			for (int i = 0; i < 4; i++) begin
				case ($urandom_range(0, 6))
					0: word[i*8 +: 8] = 8'h00;
					1: word[i*8 +: 8] = 8'hFF;
					2: word[i*8 +: 8] = 8'h10;
					3: word[i*8 +: 8] = 8'hEB;
					4: word[i*8 +: 8] = 8'h80;
					5: word[i*8 +: 8] = 8'hF0;
					default: ;
				endcase
			end
		end
		return word;
	endfunction

	// Offer one macropixel and hold it until the transfer; steady suppresses gaps
	task automatic send_macropixel(input logic [31:0] word, input bit steady);
		if (!in_valid)
			in_valid <= 1'b1;
		macropixel <= word;
		do @(posedge clk); while (in_stall);
		sent++;
		if (!steady) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
					: $urandom_range(0, 8);
			end
		end
	endtask

	// Drop valid, wait for every expected pixel, then let the pipeline drain
	task automatic settle();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all three registers back to back, valid held high throughout
	task automatic load_settings(input logic [1:0] enc, input logic luma,
			input logic [1:0] cb);
		cfg_valid <= 1'b1;
		cfg_index <= REG_COLOR_ENCODING;
		cfg_data  <= enc;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_LUMA_POSITION;
		cfg_data  <= {1'b0, luma};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_BLUE_CHROMA_POSITION;
		cfg_data  <= cb;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	// Receiver: stall pattern changes every span; one long hold-off on request
	initial begin : receiver
		stall_mode_e mode;
		int span;
		int hold_cycles;
		int tick;
		out_stall   = 1'b0;
		mode        = STALL_NONE;
		span        = 0;
		hold_cycles = 0;
		tick        = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req && hold_cycles < HOLD_LEN) begin
				out_stall <= 1'b1;
				hold_cycles++;
			end else begin
				if (span == 0) begin
					mode = stall_mode_e'($urandom_range(0, 2));
					span = $urandom_range(8, 64);
				end
				span--;
				case (mode)
					STALL_RANDOM:   out_stall <= ($urandom_range(0, 1) == 1);
					STALL_PERIODIC: out_stall <= (tick % 4 == 3);
					default:        out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Bound the run in case the block locks up
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$error("timeout after %0d cycles with %0d pixels outstanding", cycles, pending);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] directed_words[8];
		logic [1:0]  enc;
		logic        luma;
		logic [1:0]  cb;
		bit          steady;

		arst_n          = 1'b0;
		in_valid        = 1'b0;
		macropixel      = '0;
		cfg_valid       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		hold_req        = 1'b0;
		sent            = 0;
		settings_loaded = 0;
		burst_left      = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default layout is Y0 Cb Y1 Cr from the low byte up
		directed_words[0] = 32'h0000_0000;
		directed_words[1] = 32'hFFFF_FFFF;
		directed_words[2] = {8'h80, 8'h10, 8'h80, 8'h10};   // black
		directed_words[3] = {8'h80, 8'hEB, 8'h80, 8'hEB};   // white
		directed_words[4] = {8'hFF, 8'hFF, 8'h00, 8'h00};   // Cr high, Cb low
		directed_words[5] = {8'h00, 8'h00, 8'hFF, 8'hFF};   // Cr low, Cb high
		directed_words[6] = 32'hAAAA_AAAA;
		directed_words[7] = 32'h5555_5555;
		foreach (directed_words[i])
			send_macropixel(directed_words[i], 1'b0);

		// Remaining matrices, including the spare code; chroma landing on luma bytes
		for (int s = 0; s < 3; s++) begin
			settle();
			case (s)
				0:       load_settings(ENC_BT709, 1'b1, 2'd0);
				1:       load_settings(ENC_BT2020, 1'b0, 2'd2);
				default: load_settings(ENC_SPARE, 1'b1, 2'd3);
			endcase
			send_macropixel(32'h0000_0000, 1'b0);
			send_macropixel(32'hFFFF_FFFF, 1'b0);
			send_macropixel(32'hA5A5_5A5A, 1'b0);
			send_macropixel(rand_word(), 1'b0);
		end

		// Random phases: extremes of the registers first, then random settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			case (p)
				0: begin enc = ENC_SPARE;  luma = 1'b1; cb = 2'd0; end
				1: begin enc = ENC_BT601;  luma = 1'b0; cb = 2'd3; end
				2: begin enc = ENC_BT2020; luma = 1'b1; cb = 2'd3; end
				3: begin enc = ENC_BT709;  luma = 1'b0; cb = 2'd0; end
				default: begin
					enc  = 2'($urandom_range(0, 3));
					luma = 1'($urandom_range(0, 1));
					cb   = 2'($urandom_range(0, 3));
				end
			endcase
			load_settings(enc, luma, cb);
			steady = (p == HOLD_PHASE);
			if (steady)
				hold_req <= 1'b1;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (p == PAUSE_PHASE && i == ITEMS_PER_PHASE / 2)
					settle();
				send_macropixel(rand_word(), steady);
			end
		end

		settle();
		$display("Sent %0d macropixels, checked %0d pixels over %0d register settings",
			sent, pixels_checked, settings_loaded);
		$display("Covered all encoding codes, every luma and chroma position, a long hold-off");
		if (failures == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
